@@ sv/cau_pkg.sv @@
// shared types and constants for the complex arithmetic unit
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic valid;
		logic dz;
	} ctrl_t;

endpackage

@@ sv/cau_front.sv @@
// front end: operand capture, products, sums and magnitude for the divide lanes
module cau_front #(
	parameter int W = cau_pkg::DATA_WIDTH_DEF,
	parameter int F = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  cau_pkg::op_t             kind,
	input  logic signed [W-1:0]      a_real,
	input  logic signed [W-1:0]      a_imag,
	input  logic signed [W-1:0]      b_real,
	input  logic signed [W-1:0]      b_imag,
	output cau_pkg::ctrl_t           ctrl,
	output logic [2*W+F:0]           mag_re,
	output logic                     neg_re,
	output logic [2*W+F:0]           mag_im,
	output logic                     neg_im,
	output logic [2*W-1:0]           den
);
	import cau_pkg::*;

	localparam int NW = 2*W + 1 + F;
	localparam int PW = 2*W;

	// stage 1: request capture
	logic                vld_s1;
	op_t                 kind_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		ar_s1   <= a_real;
		ai_s1   <= a_imag;
		br_s1   <= b_real;
		bi_s1   <= b_imag;
	end

	// stage 2: products and linear sums
	logic                 vld_s2, dz_s2;
	op_t                  kind_s2;
	logic signed [PW-1:0] prr_s2, pii_s2, pri_s2, pir_s2, sqr_s2, sqi_s2;
	logic signed [W:0]    sre_s2, sim_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		dz_s2   <= (kind_s1 == OP_DIV) && (br_s1 == '0) && (bi_s1 == '0);
		prr_s2  <= PW'(ar_s1) * PW'(br_s1);
		pii_s2  <= PW'(ai_s1) * PW'(bi_s1);
		pri_s2  <= PW'(ar_s1) * PW'(bi_s1);
		pir_s2  <= PW'(ai_s1) * PW'(br_s1);
		sqr_s2  <= PW'(br_s1) * PW'(br_s1);
		sqi_s2  <= PW'(bi_s1) * PW'(bi_s1);
		if (kind_s1 == OP_SUB) begin
			sre_s2 <= (W+1)'(ar_s1) - (W+1)'(br_s1);
			sim_s2 <= (W+1)'(ai_s1) - (W+1)'(bi_s1);
		end else begin
			sre_s2 <= (W+1)'(ar_s1) + (W+1)'(br_s1);
			sim_s2 <= (W+1)'(ai_s1) + (W+1)'(bi_s1);
		end
	end

	// stage 3: combine products or sums into one wide value per part
	logic signed [PW:0]   xrr, xii, xri, xir;
	logic signed [PW:0]   mre, mim, dre, dim;
	logic signed [NW-1:0] val_re_d, val_im_d;
	logic [PW-1:0]        den_d;

	always_comb begin
		xrr = (PW+1)'(prr_s2);
		xii = (PW+1)'(pii_s2);
		xri = (PW+1)'(pri_s2);
		xir = (PW+1)'(pir_s2);
		mre = xrr - xii;
		mim = xri + xir;
		dre = xrr + xii;
		dim = xir - xri;
		den_d = PW'(1);
		case (kind_s2)
			OP_MUL: begin
				val_re_d = NW'(mre) >>> F;
				val_im_d = NW'(mim) >>> F;
			end
			OP_DIV: begin
				if (dz_s2) begin
					val_re_d = '0;
					val_im_d = '0;
				end else begin
					val_re_d = NW'(dre) <<< F;
					val_im_d = NW'(dim) <<< F;
					den_d    = PW'(sqr_s2) + PW'(sqi_s2);
				end
			end
			default: begin
				val_re_d = NW'(sre_s2);
				val_im_d = NW'(sim_s2);
			end
		endcase
	end

	logic                 vld_s3, dz_s3;
	logic signed [NW-1:0] val_re_s3, val_im_s3;
	logic [PW-1:0]        den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dz_s3     <= dz_s2;
		val_re_s3 <= val_re_d;
		val_im_s3 <= val_im_d;
		den_s3    <= den_d;
	end

	// stage 4: sign and magnitude
	logic            vld_s4, dz_s4;
	logic [NW-1:0]   mag_re_s4, mag_im_s4;
	logic            neg_re_s4, neg_im_s4;
	logic [PW-1:0]   den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dz_s4     <= dz_s3;
		neg_re_s4 <= val_re_s3[NW-1];
		neg_im_s4 <= val_im_s3[NW-1];
		mag_re_s4 <= val_re_s3[NW-1] ? NW'(-val_re_s3) : NW'(val_re_s3);
		mag_im_s4 <= val_im_s3[NW-1] ? NW'(-val_im_s3) : NW'(val_im_s3);
		den_s4    <= den_s3;
	end

	assign ctrl.valid = vld_s4;
	assign ctrl.dz    = dz_s4;
	assign mag_re     = mag_re_s4;
	assign neg_re     = neg_re_s4;
	assign mag_im     = mag_im_s4;
	assign neg_im     = neg_im_s4;
	assign den        = den_s4;

endmodule

@@ sv/cau_div_lane.sv @@
// pipelined restoring divider, one quotient bit per stage
module cau_div_lane #(
	parameter int W  = cau_pkg::DATA_WIDTH_DEF,
	parameter int NW = 2*cau_pkg::DATA_WIDTH_DEF + 1 + cau_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic [NW-1:0]   mag,
	input  logic [2*W-1:0]  den,
	input  logic            neg,
	output logic [W-1:0]    quo,
	output logic            big,
	output logic            neg_out
);
	localparam int RW = NW + W;

	logic [RW-1:0] rem_s [0:W];
	logic [RW-1:0] den_s [0:W];
	logic [W-1:0]  quo_s [0:W];
	logic          neg_s [0:W];
	logic          big_s [0:W];

	// register the inputs and flag a quotient too large for the result width
	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(mag);
		den_s[0] <= RW'(den);
		quo_s[0] <= '0;
		neg_s[0] <= neg;
		big_s[0] <= RW'(mag) >= (RW'(den) << W);
	end

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int K = W - 1 - i;
		logic [RW-1:0] cand;
		logic          take;

		assign cand = den_s[i] << K;
		assign take = rem_s[i] >= cand;

		always_ff @(posedge clk) begin
			rem_s[i+1] <= take ? (rem_s[i] - cand) : rem_s[i];
			quo_s[i+1] <= take ? (quo_s[i] | (W'(1) << K)) : quo_s[i];
			den_s[i+1] <= den_s[i];
			neg_s[i+1] <= neg_s[i];
			big_s[i+1] <= big_s[i];
		end
	end

	assign quo     = quo_s[W];
	assign big     = big_s[W];
	assign neg_out = neg_s[W];

endmodule

@@ sv/complex_arith_unit.sv @@
// complex arithmetic unit top level: front end, two divide lanes, saturation
// throughput: one request per cycle, set by the one-bit-per-stage divide lanes
// every operation takes the divide lanes, so results leave in request order
// busy is always low; arst_n clears all valid bits and the flags
module complex_arith_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cau_pkg::op_t                 kind,
	input  logic signed [DATA_WIDTH-1:0] a_real,
	input  logic signed [DATA_WIDTH-1:0] a_imag,
	input  logic signed [DATA_WIDTH-1:0] b_real,
	input  logic signed [DATA_WIDTH-1:0] b_imag,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_real,
	output logic signed [DATA_WIDTH-1:0] res_imag,
	output logic                         div_zero,
	output logic                         overflow
);
	import cau_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int NW = 2*W + 1 + FRAC_BITS;

	ctrl_t           ctrl_f;
	logic [NW-1:0]   mag_re, mag_im;
	logic            neg_re, neg_im;
	logic [2*W-1:0]  den;

	cau_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.a_real (a_real),
		.a_imag (a_imag),
		.b_real (b_real),
		.b_imag (b_imag),
		.ctrl   (ctrl_f),
		.mag_re (mag_re),
		.neg_re (neg_re),
		.mag_im (mag_im),
		.neg_im (neg_im),
		.den    (den)
	);

	logic [W-1:0] quo_re, quo_im;
	logic         big_re, big_im, sgn_re, sgn_im;

	cau_div_lane #(.W(W), .NW(NW)) u_lane_re (
		.clk     (clk),
		.mag     (mag_re),
		.den     (den),
		.neg     (neg_re),
		.quo     (quo_re),
		.big     (big_re),
		.neg_out (sgn_re)
	);

	cau_div_lane #(.W(W), .NW(NW)) u_lane_im (
		.clk     (clk),
		.mag     (mag_im),
		.den     (den),
		.neg     (neg_im),
		.quo     (quo_im),
		.big     (big_im),
		.neg_out (sgn_im)
	);

	// control travels alongside the lanes
	ctrl_t ctrl_s [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= W; i++) begin
				ctrl_s[i] <= '0;
			end
		end else begin
			ctrl_s[0] <= ctrl_f;
			for (int i = 1; i <= W; i++) begin
				ctrl_s[i] <= ctrl_s[i-1];
			end
		end
	end

	function automatic logic [W:0] sat(input logic [W-1:0] q, input logic b, input logic n);
		logic         ov;
		logic [W-1:0] v;
		if (!n) begin
			ov = b | q[W-1];
			v  = ov ? {1'b0, {(W-1){1'b1}}} : q;
		end else begin
			ov = b | (q[W-1] & (|q[W-2:0]));
			v  = ov ? {1'b1, {(W-1){1'b0}}} : W'(-q);
		end
		return {ov, v};
	endfunction

	logic [W:0] sat_re, sat_im;

	always_comb begin
		sat_re = sat(quo_re, big_re, sgn_re);
		sat_im = sat(quo_im, big_im, sgn_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done     <= 1'b0;
			div_zero <= 1'b0;
			overflow <= 1'b0;
		end else begin
			done     <= ctrl_s[W].valid;
			div_zero <= ctrl_s[W].valid & ctrl_s[W].dz;
			overflow <= ctrl_s[W].valid & (sat_re[W] | sat_im[W]);
		end
	end

	always_ff @(posedge clk) begin
		res_real <= sat_re[W-1:0];
		res_imag <= sat_im[W-1:0];
	end

	assign busy = 1'b0;

endmodule

@@ sv/cau_checker.sv @@
// port-level checks for the complex arithmetic unit, bound to the top level
module cau_checker #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input cau_pkg::op_t          kind,
	input logic [DATA_WIDTH-1:0] b_real,
	input logic [DATA_WIDTH-1:0] b_imag,
	input logic                  done,
	input logic [DATA_WIDTH-1:0] res_real,
	input logic [DATA_WIDTH-1:0] res_imag,
	input logic                  div_zero,
	input logic                  overflow
);
	import cau_pkg::*;

	localparam int LAT = DATA_WIDTH + 6;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("request without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !div_zero && !overflow)
		else $error("flag without result");

	a_dz_result: assert property (@(posedge clk) disable iff (!arst_n)
		div_zero |-> !overflow && res_real == '0 && res_imag == '0)
		else $error("zero divisor result not cleared");

	a_dz_flag: assert property (@(posedge clk) disable iff (!arst_n)
		start && kind == OP_DIV && b_real == '0 && b_imag == '0 |-> ##LAT div_zero)
		else $error("zero divisor not flagged");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.kind     (kind),
	.b_real   (b_real),
	.b_imag   (b_imag),
	.done     (done),
	.res_real (res_real),
	.res_imag (res_imag),
	.div_zero (div_zero),
	.overflow (overflow)
);
